// ===== rtl/core/segment_box_trace_assert.svh =====
// Assertion helpers for the segment trace RTL.
`ifndef SEGMENT_BOX_TRACE_ASSERT_SVH
`define SEGMENT_BOX_TRACE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, held off during reset.
`define SBT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("segment_box_trace: implication check failed");

// Next-cycle implication, held off during reset.
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("segment_box_trace: next-cycle check failed");

`else

`define SBT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sbt_pkg.sv =====
`timescale 1ns / 1ps

package sbt_pkg;

    localparam int MAX_BOXES   = 16;
    localparam int BOX_W       = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int BCNT_W      = $clog2(MAX_BOXES + 1);
    localparam int CFG_CNT_W   = 5;
    localparam int C_W         = 24;
    localparam int HE_W        = 23;
    localparam int IDX_W       = 4;
    localparam int T_FRAC_BITS = 16;
    localparam int T_W         = T_FRAC_BITS + 4;
    localparam int Q_W         = T_FRAC_BITS + 2;
    localparam int QCNT_W      = $clog2(Q_W + 1);
    localparam int B_W         = C_W + 1;
    localparam int N_W         = C_W + 3;
    localparam int A_W         = N_W - 1;
    localparam int D_W         = C_W + 1;
    localparam int P_W         = D_W + T_W;

    typedef logic signed [C_W-1:0] t_coord;
    typedef logic signed [T_W-1:0] t_time;

    localparam t_time T_ONE  = t_time'(1 << T_FRAC_BITS);
    localparam t_time T_NONE = t_time'(2 << T_FRAC_BITS);
    localparam t_time T_SAT  = t_time'((1 << Q_W) - 1);
    localparam t_time T_NEG  = t_time'(-1);

    localparam logic CFG_HALF_EXTENT = 1'b0;
    localparam logic CFG_BOX_COUNT   = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Z = 2'd1;
    localparam logic [1:0] AX_Y = 2'd2;

    localparam logic [1:0] WALL_XP = 2'd0;
    localparam logic [1:0] WALL_XN = 2'd1;
    localparam logic [1:0] WALL_ZP = 2'd2;
    localparam logic [1:0] WALL_ZN = 2'd3;

    typedef enum logic [1:0] {
        OP_FLOOR,
        OP_WALL,
        OP_SLAB_LO,
        OP_SLAB_HI
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_BOX_RD,
        S_BOX_END,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        t_coord cx;
        t_coord cz;
        t_coord hx;
        t_coord hz;
        t_coord h;
    } t_box;

    localparam int BOX_ENT_W = $bits(t_box);

    typedef struct packed {
        logic             wr;
        logic             load;
        t_op              op;
        logic [1:0]       sel;
        logic [BOX_W-1:0] box;
        logic             div_go;
        logic             apply;
        logic             box_init;
        logic             box_take;
        logic             mul_go;
        logic [1:0]       mul_sel;
        logic             add_go;
        logic [1:0]       add_sel;
        logic             emit;
    } t_cmd;

    typedef struct packed {
        logic cond;
        logic in_range;
        logic div_done;
        logic slab_ok;
    } t_stat;

endpackage

// ===== rtl/core/sbt_ram.sv =====
`timescale 1ns / 1ps

module sbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sbt_div.sv =====
`timescale 1ns / 1ps

module sbt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic signed [sbt_pkg::N_W-1:0] i_num,
    input  logic [sbt_pkg::D_W-1:0]        i_den,
    output logic                           o_done,
    output sbt_pkg::t_time                 o_quo
);

    logic                              r_busy;
    logic                              r_done;
    logic [sbt_pkg::QCNT_W-1:0]        r_cnt;
    logic [sbt_pkg::D_W-1:0]           r_rem;
    logic [sbt_pkg::D_W-1:0]           r_den;
    logic [sbt_pkg::Q_W-1:0]           r_sh;
    logic [sbt_pkg::Q_W-1:0]           r_q;
    sbt_pkg::t_time                    r_quo;

    logic [sbt_pkg::A_W-1:0]           mag;
    logic                              sat;
    logic [sbt_pkg::D_W:0]             trial;
    logic                              ge;
    logic [sbt_pkg::D_W-1:0]           n_rem;

    assign mag   = sbt_pkg::A_W'(i_num);
    // quotient would need more than Q_W bits: clamp, the caller only compares it
    assign sat   = {1'b0, mag} >= {i_den, 2'b00};
    assign trial = {r_rem, r_sh[sbt_pkg::Q_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign n_rem = ge ? sbt_pkg::D_W'(trial - {1'b0, r_den}) : sbt_pkg::D_W'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                if (i_num < 0) begin
                    // any negative time acts alike downstream
                    r_quo  <= sbt_pkg::T_NEG;
                    r_done <= 1'b1;
                end else if (sat) begin
                    r_quo  <= sbt_pkg::T_SAT;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_rem  <= sbt_pkg::D_W'(mag >> 2);
                    r_sh   <= {mag[1:0], {sbt_pkg::T_FRAC_BITS{1'b0}}};
                    r_den  <= i_den;
                    r_q    <= '0;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_sh  <= {r_sh[sbt_pkg::Q_W-2:0], 1'b0};
                r_q   <= {r_q[sbt_pkg::Q_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sbt_pkg::QCNT_W'(sbt_pkg::Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quo  <= sbt_pkg::T_W'({1'b0, r_q[sbt_pkg::Q_W-2:0], ge});
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/sbt_dp.sv =====
`timescale 1ns / 1ps

module sbt_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sbt_pkg::t_cmd            i_cmd_ctl,
    output sbt_pkg::t_stat           o_st,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [sbt_pkg::HE_W-1:0] i_cfg_data,
    input  logic [sbt_pkg::IDX_W-1:0] i_entry_index,
    input  sbt_pkg::t_coord          i_x_a,
    input  sbt_pkg::t_coord          i_y_a,
    input  sbt_pkg::t_coord          i_z_a,
    input  sbt_pkg::t_coord          i_x_b,
    input  sbt_pkg::t_coord          i_y_b,
    input  sbt_pkg::t_coord          i_z_b,
    output logic                     o_strobe,
    output logic                     o_hit,
    output sbt_pkg::t_coord          o_hit_x,
    output sbt_pkg::t_coord          o_hit_y,
    output sbt_pkg::t_coord          o_hit_z
);

    logic [sbt_pkg::HE_W-1:0] r_half;
    sbt_pkg::t_coord r_x0, r_y0, r_z0, r_x1, r_y1, r_z1;
    sbt_pkg::t_time  r_best, r_enter, r_leave, r_tlo;
    logic signed [sbt_pkg::P_W-1:0] r_prod;
    sbt_pkg::t_coord r_px, r_py, r_pz;
    logic            r_strobe, r_hit;
    sbt_pkg::t_coord r_ox, r_oy, r_oz;

    sbt_pkg::t_box                   ent;
    logic [sbt_pkg::BOX_ENT_W-1:0]   ram_q;
    logic                            ram_we;

    logic signed [sbt_pkg::D_W-1:0]  dx, dy, dz;
    logic signed [sbt_pkg::N_W-1:0]  w, x0e, y0e, z0e, x1e, y1e, z1e;
    logic signed [sbt_pkg::N_W-1:0]  ax_st, ax_lo, ax_hi, ax_dl, bnd, nraw;
    logic signed [sbt_pkg::N_W-1:0]  num, den_s;
    logic [sbt_pkg::D_W-1:0]         den;
    logic                            cond;

    logic                            div_done;
    sbt_pkg::t_time                  quo, t1, t2, ne, nl;
    logic signed [sbt_pkg::D_W-1:0]  mdl;
    sbt_pkg::t_coord                 ast, pv;
    logic                            hit_now;

    assign ram_we = i_cmd_ctl.wr && (32'(i_entry_index) < sbt_pkg::MAX_BOXES);

    sbt_ram #(
        .WIDTH (sbt_pkg::BOX_ENT_W),
        .DEPTH (sbt_pkg::MAX_BOXES)
    ) u_boxes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (sbt_pkg::BOX_W'(i_entry_index)),
        .i_wdata ({i_x_a, i_z_a, i_x_b, i_z_b, i_y_b}),
        .i_raddr (i_cmd_ctl.box),
        .o_rdata (ram_q)
    );

    assign ent = sbt_pkg::t_box'(ram_q);

    assign dx  = sbt_pkg::D_W'(r_x1) - sbt_pkg::D_W'(r_x0);
    assign dy  = sbt_pkg::D_W'(r_y1) - sbt_pkg::D_W'(r_y0);
    assign dz  = sbt_pkg::D_W'(r_z1) - sbt_pkg::D_W'(r_z0);
    assign w   = sbt_pkg::N_W'({1'b0, r_half});
    assign x0e = sbt_pkg::N_W'(r_x0);
    assign y0e = sbt_pkg::N_W'(r_y0);
    assign z0e = sbt_pkg::N_W'(r_z0);
    assign x1e = sbt_pkg::N_W'(r_x1);
    assign y1e = sbt_pkg::N_W'(r_y1);
    assign z1e = sbt_pkg::N_W'(r_z1);

    // operand selection for the shared divider
    always_comb begin
        case (i_cmd_ctl.sel)
            sbt_pkg::AX_X: begin
                ax_st = x0e;
                ax_dl = sbt_pkg::N_W'(dx);
                ax_lo = sbt_pkg::N_W'(ent.cx) - sbt_pkg::N_W'(ent.hx);
                ax_hi = sbt_pkg::N_W'(ent.cx) + sbt_pkg::N_W'(ent.hx);
            end
            sbt_pkg::AX_Z: begin
                ax_st = z0e;
                ax_dl = sbt_pkg::N_W'(dz);
                ax_lo = sbt_pkg::N_W'(ent.cz) - sbt_pkg::N_W'(ent.hz);
                ax_hi = sbt_pkg::N_W'(ent.cz) + sbt_pkg::N_W'(ent.hz);
            end
            default: begin
                ax_st = y0e;
                ax_dl = sbt_pkg::N_W'(dy);
                ax_lo = '0;
                ax_hi = sbt_pkg::N_W'(ent.h);
            end
        endcase
        bnd  = (i_cmd_ctl.op == sbt_pkg::OP_SLAB_LO) ? ax_lo : ax_hi;
        nraw = bnd - ax_st;

        case (i_cmd_ctl.op)
            sbt_pkg::OP_FLOOR: begin
                cond  = (y1e <= 0) && (y0e > 0);
                num   = y0e;
                den_s = y0e - y1e;
            end
            sbt_pkg::OP_WALL: begin
                case (i_cmd_ctl.sel)
                    sbt_pkg::WALL_XP: begin
                        cond  = (x1e > w) && (dx > 0) && (w - x0e >= 0);
                        num   = w - x0e;
                        den_s = sbt_pkg::N_W'(dx);
                    end
                    sbt_pkg::WALL_XN: begin
                        cond  = (x1e < -w) && (dx < 0) && (x0e + w >= 0);
                        num   = x0e + w;
                        den_s = -sbt_pkg::N_W'(dx);
                    end
                    sbt_pkg::WALL_ZP: begin
                        cond  = (z1e > w) && (dz > 0) && (w - z0e >= 0);
                        num   = w - z0e;
                        den_s = sbt_pkg::N_W'(dz);
                    end
                    default: begin
                        cond  = (z1e < -w) && (dz < 0) && (z0e + w >= 0);
                        num   = z0e + w;
                        den_s = -sbt_pkg::N_W'(dz);
                    end
                endcase
            end
            default: begin
                // slab bounds: flip sign so the divisor is positive
                cond  = ax_dl != 0;
                num   = (ax_dl < 0) ? -nraw : nraw;
                den_s = (ax_dl < 0) ? -ax_dl : ax_dl;
            end
        endcase
        den = sbt_pkg::D_W'(den_s);
    end

    sbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd_ctl.div_go),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign t1 = (r_tlo < quo) ? r_tlo : quo;
    assign t2 = (r_tlo < quo) ? quo : r_tlo;
    assign ne = (t1 > r_enter) ? t1 : r_enter;
    assign nl = (t2 < r_leave) ? t2 : r_leave;

    assign o_st.cond     = cond;
    assign o_st.in_range = (ax_st >= ax_lo) && (ax_st <= ax_hi);
    assign o_st.div_done = div_done;
    assign o_st.slab_ok  = ne <= nl;

    always_comb begin
        case (i_cmd_ctl.mul_sel)
            sbt_pkg::AX_X: mdl = dx;
            sbt_pkg::AX_Z: mdl = dz;
            default:       mdl = dy;
        endcase
        case (i_cmd_ctl.add_sel)
            sbt_pkg::AX_X: ast = r_x0;
            sbt_pkg::AX_Z: ast = r_z0;
            default:       ast = r_y0;
        endcase
        pv = sbt_pkg::C_W'(r_prod >>> sbt_pkg::T_FRAC_BITS);
    end

    assign hit_now = r_best <= sbt_pkg::T_ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd_ctl.emit;
            if (i_cfg_we && i_cfg_idx == sbt_pkg::CFG_HALF_EXTENT) begin
                r_half <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_x0 <= i_x_a;
            r_y0 <= i_y_a;
            r_z0 <= i_z_a;
            r_x1 <= i_x_b;
            r_y1 <= i_y_b;
            r_z1 <= i_z_b;
            // start and end both at or below the floor: hit at the start
            r_best <= (i_y_b <= 0 && i_y_a <= 0) ? '0 : sbt_pkg::T_NONE;
        end else if (i_cmd_ctl.apply) begin
            case (i_cmd_ctl.op)
                sbt_pkg::OP_SLAB_LO: r_tlo <= quo;
                sbt_pkg::OP_SLAB_HI: begin
                    r_enter <= ne;
                    r_leave <= nl;
                end
                default: begin
                    if (quo < r_best) begin
                        r_best <= quo;
                    end
                end
            endcase
        end else if (i_cmd_ctl.box_take) begin
            if (r_enter < r_best) begin
                r_best <= r_enter;
            end
        end
        if (i_cmd_ctl.box_init) begin
            r_enter <= '0;
            r_leave <= sbt_pkg::T_ONE;
        end
        if (i_cmd_ctl.mul_go) begin
            r_prod <= sbt_pkg::P_W'(mdl) * sbt_pkg::P_W'(r_best);
        end
        if (i_cmd_ctl.add_go) begin
            case (i_cmd_ctl.add_sel)
                sbt_pkg::AX_X: r_px <= ast + pv;
                sbt_pkg::AX_Z: r_pz <= ast + pv;
                default:       r_py <= ast + pv;
            endcase
        end
        if (i_cmd_ctl.emit) begin
            r_hit <= hit_now;
            r_ox  <= hit_now ? r_px : '0;
            r_oy  <= hit_now ? r_py : '0;
            r_oz  <= hit_now ? r_pz : '0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_hit    = r_hit;
    assign o_hit_x  = r_ox;
    assign o_hit_y  = r_oy;
    assign o_hit_z  = r_oz;

endmodule

// ===== rtl/core/sbt_ctrl.sv =====
`timescale 1ns / 1ps
`include "segment_box_trace_assert.svh"

module sbt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_cmd,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [sbt_pkg::CFG_CNT_W-1:0] i_cfg_cnt,
    input  sbt_pkg::t_stat                i_st,
    output sbt_pkg::t_cmd                 o_cmd,
    output logic                          o_busy
);

    sbt_pkg::t_state                  r_state, n_state;
    sbt_pkg::t_op                     r_op, n_op;
    logic [1:0]                       r_sel, n_sel;
    logic [sbt_pkg::BCNT_W-1:0]       r_box, n_box;
    logic [1:0]                       r_mcnt, n_mcnt;
    logic [sbt_pkg::CFG_CNT_W-1:0]    r_box_count;
    logic [sbt_pkg::BCNT_W-1:0]       box_lim;
    logic [sbt_pkg::BCNT_W-1:0]       box_nxt;
    logic                             op_done, axis_done, box_next;

    assign box_lim = (32'(r_box_count) > sbt_pkg::MAX_BOXES) ?
                     sbt_pkg::BCNT_W'(sbt_pkg::MAX_BOXES) :
                     sbt_pkg::BCNT_W'(r_box_count);
    assign box_nxt = r_box + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbt_pkg::S_IDLE;
            r_op        <= sbt_pkg::OP_FLOOR;
            r_sel       <= '0;
            r_box       <= '0;
            r_mcnt      <= '0;
            r_box_count <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_sel   <= n_sel;
            r_box   <= n_box;
            r_mcnt  <= n_mcnt;
            if (i_cfg_we && i_cfg_idx == sbt_pkg::CFG_BOX_COUNT) begin
                r_box_count <= i_cfg_cnt;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_sel     = r_sel;
        n_box     = r_box;
        n_mcnt    = '0;
        op_done   = 1'b0;
        axis_done = 1'b0;
        box_next  = 1'b0;
        o_cmd         = '0;
        o_cmd.op      = r_op;
        o_cmd.sel     = r_sel;
        o_cmd.box     = r_box[sbt_pkg::BOX_W-1:0];
        o_cmd.mul_sel = r_mcnt;
        o_cmd.add_sel = r_mcnt - 2'd1;

        case (r_state)
            sbt_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == sbt_pkg::CMD_TRACE) begin
                        o_cmd.load = 1'b1;
                        n_op       = sbt_pkg::OP_FLOOR;
                        n_sel      = '0;
                        n_state    = sbt_pkg::S_ISSUE;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            sbt_pkg::S_ISSUE: begin
                if (i_st.cond) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = sbt_pkg::S_WAIT;
                end else if (r_op == sbt_pkg::OP_SLAB_LO || r_op == sbt_pkg::OP_SLAB_HI) begin
                    // still along this axis: pass only if the start sits in the slab
                    if (i_st.in_range) begin
                        axis_done = 1'b1;
                    end else begin
                        box_next = 1'b1;
                    end
                end else begin
                    op_done = 1'b1;
                end
            end
            sbt_pkg::S_WAIT: begin
                if (i_st.div_done) begin
                    o_cmd.apply = 1'b1;
                    case (r_op)
                        sbt_pkg::OP_SLAB_LO: begin
                            n_op    = sbt_pkg::OP_SLAB_HI;
                            n_state = sbt_pkg::S_ISSUE;
                        end
                        sbt_pkg::OP_SLAB_HI: begin
                            if (i_st.slab_ok) begin
                                axis_done = 1'b1;
                            end else begin
                                box_next = 1'b1;
                            end
                        end
                        default: op_done = 1'b1;
                    endcase
                end
            end
            sbt_pkg::S_BOX_RD: begin
                o_cmd.box_init = 1'b1;
                n_op           = sbt_pkg::OP_SLAB_LO;
                n_sel          = sbt_pkg::AX_X;
                n_state        = sbt_pkg::S_ISSUE;
            end
            sbt_pkg::S_BOX_END: begin
                o_cmd.box_take = 1'b1;
                box_next       = 1'b1;
            end
            sbt_pkg::S_MUL: begin
                o_cmd.mul_go = r_mcnt != 2'd3;
                o_cmd.add_go = r_mcnt != 2'd0;
                n_mcnt       = r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    n_state = sbt_pkg::S_DONE;
                end
            end
            sbt_pkg::S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = sbt_pkg::S_IDLE;
            end
            default: n_state = sbt_pkg::S_IDLE;
        endcase

        if (op_done) begin
            if (r_op == sbt_pkg::OP_FLOOR) begin
                n_op    = sbt_pkg::OP_WALL;
                n_sel   = sbt_pkg::WALL_XP;
                n_state = sbt_pkg::S_ISSUE;
            end else if (r_sel != sbt_pkg::WALL_ZN) begin
                n_sel   = r_sel + 2'd1;
                n_state = sbt_pkg::S_ISSUE;
            end else begin
                n_box   = '0;
                n_state = (box_lim == '0) ? sbt_pkg::S_MUL : sbt_pkg::S_BOX_RD;
            end
        end
        if (axis_done) begin
            if (r_sel == sbt_pkg::AX_Y) begin
                n_state = sbt_pkg::S_BOX_END;
            end else begin
                n_op    = sbt_pkg::OP_SLAB_LO;
                n_sel   = (r_sel == sbt_pkg::AX_X) ? sbt_pkg::AX_Z : sbt_pkg::AX_Y;
                n_state = sbt_pkg::S_ISSUE;
            end
        end
        if (box_next) begin
            n_box   = box_nxt;
            n_state = (box_nxt == box_lim) ? sbt_pkg::S_MUL : sbt_pkg::S_BOX_RD;
        end
    end

    assign o_busy = r_state != sbt_pkg::S_IDLE;

    `SBT_ASSERT_NEXT(a_emit_then_idle, i_clk, i_rst_n, o_cmd.emit, r_state == sbt_pkg::S_IDLE)
    `SBT_ASSERT_IMPL(a_done_only_waiting, i_clk, i_rst_n, i_st.div_done, r_state == sbt_pkg::S_WAIT)
    `SBT_ASSERT_IMPL(a_box_in_table, i_clk, i_rst_n, r_state == sbt_pkg::S_BOX_RD, r_box < box_lim)

endmodule

// ===== rtl/core/segment_box_trace.sv =====
`timescale 1ns / 1ps
// Box write: taken straight from idle, busy stays low, no result beat.
// Trace: each division on the shared restoring divider is an issue, 18 quotient bits at one
// per cycle, then apply; up to 5 for floor and walls plus 6 per box, with up to 16 boxes.
// Busy stays high for the whole trace. One item at a time.
// The result beat is shown for one cycle on o_strobe; the receiver cannot stall it.
// Reset (synchronous, i_rst_n low) clears the sequencer and both registers; box table not.
module segment_box_trace (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [sbt_pkg::HE_W-1:0]  i_cfg_data,
    input  logic                      i_cmd,
    input  logic [sbt_pkg::IDX_W-1:0] i_entry_index,
    input  logic signed [23:0]        i_x_a,
    input  logic signed [23:0]        i_y_a,
    input  logic signed [23:0]        i_z_a,
    input  logic signed [23:0]        i_x_b,
    input  logic signed [23:0]        i_y_b,
    input  logic signed [23:0]        i_z_b,
    output logic                      o_strobe,
    output logic                      o_hit,
    output logic signed [23:0]        o_hit_x,
    output logic signed [23:0]        o_hit_y,
    output logic signed [23:0]        o_hit_z
);

    sbt_pkg::t_cmd  cmd_ctl;
    sbt_pkg::t_stat st;
    logic           ctl_busy;

    sbt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_cnt (i_cfg_data[sbt_pkg::CFG_CNT_W-1:0]),
        .i_st      (st),
        .o_cmd     (cmd_ctl),
        .o_busy    (ctl_busy)
    );

    sbt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_ctl     (cmd_ctl),
        .o_st          (st),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_x_a         (i_x_a),
        .i_y_a         (i_y_a),
        .i_z_a         (i_z_a),
        .i_x_b         (i_x_b),
        .i_y_b         (i_y_b),
        .i_z_b         (i_z_b),
        .o_strobe      (o_strobe),
        .o_hit         (o_hit),
        .o_hit_x       (o_hit_x),
        .o_hit_y       (o_hit_y),
        .o_hit_z       (o_hit_z)
    );

    assign busy = ctl_busy;

endmodule
